@@ rtl/sbg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared widths, register indexes, divider selects and the control/status
// structs that join the enumerator controller to its datapath.
// ----------------------------------------------------------------------------
package sbg_pkg;

  // coordinate and derived widths
  localparam int COORD_W    = 32;           // signed Q16.16 input coordinate
  localparam int PT_W       = COORD_W + 1;  // start + displacement
  localparam int Q_W        = PT_W + 1;     // signed cell coordinate
  localparam int CS_W       = 31;           // cell size register
  localparam int GW_W       = 16;           // grid width register
  localparam int KEY_W      = 32;
  localparam int ID_W       = 21;
  localparam int OUT_DATA_W = ((KEY_W + ID_W + 7) / 8) * 8;

  // divider step count, one quotient bit per cycle
  localparam int DIV_STEPS  = PT_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CS_W;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b1;
  localparam logic [CS_W-1:0] CELL_SIZE_RST  = 31'd65536;
  localparam logic [GW_W-1:0] GRID_WIDTH_RST = 16'd64;

  // which box bound goes through the shared divider
  typedef enum logic [1:0] {
    DIV_MIN_X,
    DIV_MIN_Y,
    DIV_MAX_X,
    DIV_MAX_Y
  } div_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     sum;
    logic     box1;
    logic     box2;
    logic     div_start;
    div_sel_e div_sel;
    logic     span;
    logic     mul;
    logic     base;
    logic     emit;
  } sbg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
    logic last_cell;
  } sbg_status_t;

endpackage
`default_nettype wire

@@ rtl/swept_box_grid_cell_enumerator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swept_box_grid_cell_enumerator_core
// Uniform grid broad phase insert: one vertex or edge in, one cell key word
// out for each grid cell its swept box covers.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one element per word; tuser is the kind (0 vertex, 1 edge).
//   m_axis carries one word per covered cell, x outer and y inner; tlast marks
//   the element's final cell and tuser says its span was clipped.
//   cfg_* writes cell size and grid width; write them only while idle.
// Timing:
//   After an accept the element goes through setup: the SUM, BOX1 and BOX2
//   states build end points and box, then four divisions go through one
//   shared serial divider (33 quotient bits each, one per cycle), then the
//   SPAN, MUL and BASE states build span and row key. Cells follow at one
//   word per cycle while the receiver keeps taking them.
//   s_axis_tready is high only between elements; a finished last word may
//   still wait in the output register while the next element is accepted.
// Reset and stall:
//   Reset loads the default registers and drops all valid state. When the
//   receiver stalls, the output word holds and enumeration pauses.
// ----------------------------------------------------------------------------
module swept_box_grid_cell_enumerator_core
  import sbg_pkg::*;
#(
  parameter int MAX_SPAN    = 8,
  parameter int INDEX_WIDTH = 20
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration write port
  input  wire                        cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // element stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // start_a_x, start_a_y, start_b_x, start_b_y, move_a_x, move_a_y,
  // move_b_x, move_b_y, element_index, zero fill
  input  wire  logic [((8*COORD_W + INDEX_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // mode
  input  wire                        s_axis_tuser,
  // cell word stream
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // cell_key, element_id, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  // clipped
  output logic                       m_axis_tuser
);

  sbg_cmd_t        cmd;
  sbg_status_t     status;
  logic [KEY_W-1:0] out_key;
  logic [ID_W-1:0]  out_id;

  sbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbg_datapath #(
    .MAX_SPAN    (MAX_SPAN),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (s_axis_tuser),
    .start_a_x_i     (s_axis_tdata[0*COORD_W +: COORD_W]),
    .start_a_y_i     (s_axis_tdata[1*COORD_W +: COORD_W]),
    .start_b_x_i     (s_axis_tdata[2*COORD_W +: COORD_W]),
    .start_b_y_i     (s_axis_tdata[3*COORD_W +: COORD_W]),
    .move_a_x_i      (s_axis_tdata[4*COORD_W +: COORD_W]),
    .move_a_y_i      (s_axis_tdata[5*COORD_W +: COORD_W]),
    .move_b_x_i      (s_axis_tdata[6*COORD_W +: COORD_W]),
    .move_b_y_i      (s_axis_tdata[7*COORD_W +: COORD_W]),
    .element_index_i (s_axis_tdata[8*COORD_W +: INDEX_WIDTH]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_key_o       (out_key),
    .out_id_o        (out_id),
    .out_last_o      (m_axis_tlast),
    .out_clip_o      (m_axis_tuser)
  );

  // pack the output word
  assign m_axis_tdata = {{(OUT_DATA_W - KEY_W - ID_W){1'b0}}, out_id, out_key};

endmodule
`default_nettype wire

@@ rtl/sbg_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_divider
// Serial restoring divider, one quotient bit per cycle. Divides a signed box
// bound by the cell size, truncating toward zero or rounding up positive
// values with a remainder when ceil is requested.
// ----------------------------------------------------------------------------
module sbg_divider
  import sbg_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  logic signed [PT_W-1:0] dividend_i,
  input  wire  logic [CS_W-1:0]      divisor_i,
  input  wire                        ceil_i,
  output logic                       done_o,
  output logic signed [Q_W-1:0]      quot_o
);

  logic                  busy_q, fin_q, done_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic [CS_W-1:0]       rem_q;
  logic [PT_W-1:0]       dvd_q;
  logic [CS_W-1:0]       dsr_q;
  logic                  neg_q, ceil_q;
  logic [Q_W-1:0]        quot_q;

  logic [PT_W-1:0]       dvd_u, mag;
  logic [CS_W+1:0]       diff;
  logic [Q_W-1:0]        qext, res;
  logic                  inc;

  // magnitude of the dividend
  assign dvd_u = dividend_i;
  assign mag   = dvd_u[PT_W-1] ? (~dvd_u + {{(PT_W-1){1'b0}}, 1'b1}) : dvd_u;

  // trial subtract of one step
  assign diff = {1'b0, rem_q, dvd_q[PT_W-1]} - {2'b00, dsr_q};

  // sign and rounding fix-up
  assign qext = {1'b0, dvd_q};
  assign inc  = ceil_q & (rem_q != '0) & ~neg_q;
  assign res  = neg_q ? (~qext + {{(Q_W-1){1'b0}}, 1'b1})
                      : (qext + {{(Q_W-1){1'b0}}, inc});

  // control sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= mag;
      dsr_q  <= divisor_i;
      neg_q  <= dvd_u[PT_W-1];
      ceil_q <= ceil_i;
    end else if (busy_q) begin
      if (!diff[CS_W+1]) begin
        rem_q <= diff[CS_W-1:0];
      end else begin
        rem_q <= {rem_q[CS_W-2:0], dvd_q[PT_W-1]};
      end
      dvd_q <= {dvd_q[PT_W-2:0], ~diff[CS_W+1]};
    end else if (fin_q) begin
      quot_q <= res;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

@@ rtl/sbg_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_datapath
// Holds the configuration, the element operands, the swept box, the cell
// range and the key generator, plus the output word register.
// ----------------------------------------------------------------------------
module sbg_datapath
  import sbg_pkg::*;
#(
  parameter int MAX_SPAN    = 8,
  parameter int INDEX_WIDTH = 20
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                         mode_i,
  input  wire  logic [COORD_W-1:0]    start_a_x_i,
  input  wire  logic [COORD_W-1:0]    start_a_y_i,
  input  wire  logic [COORD_W-1:0]    start_b_x_i,
  input  wire  logic [COORD_W-1:0]    start_b_y_i,
  input  wire  logic [COORD_W-1:0]    move_a_x_i,
  input  wire  logic [COORD_W-1:0]    move_a_y_i,
  input  wire  logic [COORD_W-1:0]    move_b_x_i,
  input  wire  logic [COORD_W-1:0]    move_b_y_i,
  input  wire  logic [INDEX_WIDTH-1:0] element_index_i,
  input  wire  sbg_cmd_t              cmd_i,
  output sbg_status_t                 status_o,
  input  wire                         out_ready_i,
  output logic                        out_valid_o,
  output logic [KEY_W-1:0]            out_key_o,
  output logic [ID_W-1:0]             out_id_o,
  output logic                        out_last_o,
  output logic                        out_clip_o
);

  localparam int SPAN_W = $clog2(MAX_SPAN);
  localparam logic signed [Q_W:0] SPAN_LIM = (Q_W+1)'(MAX_SPAN - 1);

  function automatic logic signed [PT_W-1:0] smin(input logic signed [PT_W-1:0] a,
                                                  input logic signed [PT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [PT_W-1:0] smax(input logic signed [PT_W-1:0] a,
                                                  input logic signed [PT_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  // configuration registers
  logic [CS_W-1:0] cell_size_q;
  logic [GW_W-1:0] grid_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q  <= CELL_SIZE_RST;
      grid_width_q <= GRID_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CELL_SIZE:  cell_size_q  <= cfg_wdata_i;
        REG_GRID_WIDTH: grid_width_q <= cfg_wdata_i[GW_W-1:0];
        default: ;
      endcase
    end
  end

  // element operands
  logic                   mode_q;
  logic [COORD_W-1:0]     sax_q, say_q, sbx_q, sby_q, max_q, may_q, mbx_q, mby_q;
  logic [INDEX_WIDTH-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      sax_q  <= start_a_x_i;
      say_q  <= start_a_y_i;
      sbx_q  <= start_b_x_i;
      sby_q  <= start_b_y_i;
      max_q  <= move_a_x_i;
      may_q  <= move_a_y_i;
      mbx_q  <= move_b_x_i;
      mby_q  <= move_b_y_i;
      idx_q  <= element_index_i;
    end
  end

  // end points and element id
  logic signed [PT_W-1:0] ax_q, ay_q, bx_q, by_q, ex_q, ey_q, fx_q, fy_q;
  logic [ID_W-1:0]        id_q;
  logic [INDEX_WIDTH:0]   id_sum;
  logic [INDEX_WIDTH+ID_W:0] id_wide;
  logic [ID_W-1:0]        id_pos;

  assign id_sum  = {1'b0, idx_q} + {{INDEX_WIDTH{1'b0}}, 1'b1};
  assign id_wide = {{ID_W{1'b0}}, id_sum};
  assign id_pos  = id_wide[ID_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      ax_q <= {sax_q[COORD_W-1], sax_q};
      ay_q <= {say_q[COORD_W-1], say_q};
      bx_q <= {sbx_q[COORD_W-1], sbx_q};
      by_q <= {sby_q[COORD_W-1], sby_q};
      ex_q <= {sax_q[COORD_W-1], sax_q} + {max_q[COORD_W-1], max_q};
      ey_q <= {say_q[COORD_W-1], say_q} + {may_q[COORD_W-1], may_q};
      fx_q <= {sbx_q[COORD_W-1], sbx_q} + {mbx_q[COORD_W-1], mbx_q};
      fy_q <= {sby_q[COORD_W-1], sby_q} + {mby_q[COORD_W-1], mby_q};
      id_q <= mode_q ? id_pos : (~id_pos + {{(ID_W-1){1'b0}}, 1'b1});
    end
  end

  // swept box, per point pair then combined
  logic signed [PT_W-1:0] amin_x_q, amax_x_q, amin_y_q, amax_y_q;
  logic signed [PT_W-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
  logic signed [PT_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.box1) begin
      amin_x_q <= smin(ax_q, ex_q);
      amax_x_q <= smax(ax_q, ex_q);
      amin_y_q <= smin(ay_q, ey_q);
      amax_y_q <= smax(ay_q, ey_q);
      bmin_x_q <= smin(bx_q, fx_q);
      bmax_x_q <= smax(bx_q, fx_q);
      bmin_y_q <= smin(by_q, fy_q);
      bmax_y_q <= smax(by_q, fy_q);
    end
    if (cmd_i.box2) begin
      min_x_q <= mode_q ? smin(amin_x_q, bmin_x_q) : amin_x_q;
      max_x_q <= mode_q ? smax(amax_x_q, bmax_x_q) : amax_x_q;
      min_y_q <= mode_q ? smin(amin_y_q, bmin_y_q) : amin_y_q;
      max_y_q <= mode_q ? smax(amax_y_q, bmax_y_q) : amax_y_q;
    end
  end

  // shared divider for the four bounds
  logic signed [PT_W-1:0] div_num;
  logic [CS_W-1:0]        div_den;
  logic                   div_done;
  logic signed [Q_W-1:0]  div_quot;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_MIN_X: div_num = min_x_q;
      DIV_MIN_Y: div_num = min_y_q;
      DIV_MAX_X: div_num = max_x_q;
      DIV_MAX_Y: div_num = max_y_q;
      default:   div_num = min_x_q;
    endcase
  end

  // a zero cell size behaves as one
  assign div_den = (cell_size_q == '0) ? {{(CS_W-1){1'b0}}, 1'b1} : cell_size_q;

  sbg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .ceil_i     (cmd_i.div_sel == DIV_MAX_X || cmd_i.div_sel == DIV_MAX_Y),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // cell range
  logic signed [Q_W-1:0] cx0_q, cy0_q, cx1_q, cy1_q;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DIV_MIN_X: cx0_q <= div_quot;
        DIV_MIN_Y: cy0_q <= div_quot;
        DIV_MAX_X: cx1_q <= div_quot;
        DIV_MAX_Y: cy1_q <= div_quot;
        default: ;
      endcase
    end
  end

  // span per axis, clipped to the cell limit
  logic signed [Q_W:0] dx, dy;
  logic                clip_x, clip_y;
  logic [SPAN_W-1:0]   nx_m1_q, ny_m1_q;
  logic                clip_q;

  assign dx     = $signed({cx1_q[Q_W-1], cx1_q}) - $signed({cx0_q[Q_W-1], cx0_q});
  assign dy     = $signed({cy1_q[Q_W-1], cy1_q}) - $signed({cy0_q[Q_W-1], cy0_q});
  assign clip_x = dx > SPAN_LIM;
  assign clip_y = dy > SPAN_LIM;

  always_ff @(posedge clk_i) begin
    if (cmd_i.span) begin
      priority if (clip_x)  nx_m1_q <= SPAN_W'(MAX_SPAN - 1);
      else if (dx[Q_W])     nx_m1_q <= '0;
      else                  nx_m1_q <= dx[SPAN_W-1:0];
      priority if (clip_y)  ny_m1_q <= SPAN_W'(MAX_SPAN - 1);
      else if (dy[Q_W])     ny_m1_q <= '0;
      else                  ny_m1_q <= dy[SPAN_W-1:0];
      clip_q <= clip_x | clip_y;
    end
  end

  // key generator: row product, then per-cell increments
  logic [KEY_W+GW_W-1:0] prod_full;
  logic [KEY_W-1:0]      prod_q, col_key_q, key_q;
  logic [SPAN_W-1:0]     i_q, j_q;
  logic                  last_cell;

  assign prod_full = cy0_q[KEY_W-1:0] * grid_width_q;
  assign last_cell = (i_q == nx_m1_q) && (j_q == ny_m1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_full[KEY_W-1:0];
    end
    if (cmd_i.base) begin
      col_key_q <= prod_q + cx0_q[KEY_W-1:0];
      key_q     <= prod_q + cx0_q[KEY_W-1:0];
      i_q       <= '0;
      j_q       <= '0;
    end else if (cmd_i.emit) begin
      if (j_q == ny_m1_q) begin
        i_q       <= i_q + 1'b1;
        j_q       <= '0;
        col_key_q <= col_key_q + {{(KEY_W-1){1'b0}}, 1'b1};
        key_q     <= col_key_q + {{(KEY_W-1){1'b0}}, 1'b1};
      end else begin
        j_q   <= j_q + 1'b1;
        key_q <= key_q + {{(KEY_W-GW_W){1'b0}}, grid_width_q};
      end
    end
  end

  // output word register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_key_o  <= key_q;
      out_id_o   <= id_q;
      out_last_o <= last_cell;
      out_clip_o <= clip_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;
  assign status_o.last_cell = last_cell;

endmodule
`default_nettype wire

@@ rtl/sbg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_ctrl
// Sequencer for one element: operand load, box build, four divisions,
// span and key setup, then one word per free output slot.
// ----------------------------------------------------------------------------
module sbg_ctrl
  import sbg_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  sbg_status_t status_i,
  output sbg_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_BOX1,
    ST_BOX2,
    ST_DIV,
    ST_DWAIT,
    ST_SPAN,
    ST_MUL,
    ST_BASE,
    ST_EMIT
  } state_e;

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic     in_ready_q;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_BOX1;
      end
      ST_BOX1: begin
        cmd_o.box1 = 1'b1;
        state_d    = ST_BOX2;
      end
      ST_BOX2: begin
        cmd_o.box2 = 1'b1;
        sel_d      = DIV_MIN_X;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status_i.div_done) begin
          if (sel_q == DIV_MAX_Y) begin
            state_d = ST_SPAN;
          end else begin
            sel_d   = div_sel_e'(sel_q + 2'd1);
            state_d = ST_DIV;
          end
        end
      end
      ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_cell) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_q      <= DIV_MIN_X;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      sel_q      <= sel_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule
`default_nettype wire

@@ rtl/sbg_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_checker
// Port-level checks on the enumerator: output hold under stall, one element
// in flight at a time, and a constant id and clip flag within an element.
// ----------------------------------------------------------------------------
module sbg_checker
  import sbg_pkg::*;
(
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    s_axis_tvalid,
  input wire                    s_axis_tready,
  input wire                    m_axis_tvalid,
  input wire                    m_axis_tready,
  input wire [OUT_DATA_W-1:0]   m_axis_tdata,
  input wire                    m_axis_tlast,
  input wire                    m_axis_tuser
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled output word changed");

  // an accepted element closes the input right after the accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input open right after accept");

  // no new element while the current one still has cells to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input open in the middle of an element");

  // id and clip flag stay fixed across the words of one element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid ||
       (m_axis_tdata[KEY_W +: ID_W] == $past(m_axis_tdata[KEY_W +: ID_W]) &&
        m_axis_tuser == $past(m_axis_tuser))))
    else $error("element id or clip flag changed within an element");

endmodule

bind swept_box_grid_cell_enumerator_core sbg_checker u_sbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ sim/swept_box_grid_cell_enumerator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swept_box_grid_cell_enumerator_core_tb
// Self-checking bench for the swept box grid cell enumerator. Elements go in
// on the slave stream with random gaps. Cell words are taken from the master
// stream with random stalls. An in-bench predictor works out the swept box,
// the cell range and the key and id of every cell as each element is
// accepted. Each word that comes out is compared with the oldest predicted
// cell. Cell size and grid width are changed between phases while idle.
// ----------------------------------------------------------------------------
module swept_box_grid_cell_enumerator_core_tb;
  import sbg_pkg::*;

  localparam int IDX_W         = 20;
  localparam int IN_DATA_W     = ((8 * COORD_W + IDX_W + 7) / 8) * 8;
  localparam int SPAN_LIMIT    = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int MAX_PRINTS    = 50;

  localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [IDX_W-1:0]          IDX_TOP = 20'hFFFFF;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_EDGE   = 1'b1
  } elem_kind_e;

  typedef struct {
    elem_kind_e                 kind;
    logic signed [COORD_W-1:0]  pa_x, pa_y, pb_x, pb_y;
    logic signed [COORD_W-1:0]  da_x, da_y, db_x, db_y;
    logic [IDX_W-1:0]           index;
  } element_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic             last;
    logic             clipped;
  } cell_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // start_a_x, start_a_y, start_b_x, start_b_y, move_a_x, move_a_y,
  // move_b_x, move_b_y, element_index, zero fill
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // mode
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // cell_key, element_id, zero fill
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;
  // clipped
  logic                   m_axis_tuser;

  // bench copy of the registers
  logic [CS_W-1:0]        cell_size_q = CELL_SIZE_RST;
  logic [GW_W-1:0]        grid_width_q = GRID_WIDTH_RST;

  cell_word_t             cells_due[$];
  int                     failures = 0;
  int                     words_seen = 0;
  bit                     no_idle = 1'b0;

  swept_box_grid_cell_enumerator_core #(
    .MAX_SPAN    (SPAN_LIMIT),
    .INDEX_WIDTH (IDX_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    failures++;
    if (failures <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic longint lesser(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint greater(input longint a, input longint b);
    return (a < b) ? b : a;
  endfunction

  // division rounding up; signed division already rounds negatives up
  function automatic longint ceil_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n > 0) q++;
    return q;
  endfunction

  // inclusive cell range to cell count, limited to the span maximum
  function automatic longint span_cells(input longint lo, input longint hi,
                                        inout logic clip);
    longint n;
    n = hi - lo + 1;
    if (n < 1) n = 1;
    if (n > SPAN_LIMIT) begin
      n = SPAN_LIMIT;
      clip = 1'b1;
    end
    return n;
  endfunction

  // queue one expected word per covered cell, x outer and y inner
  function automatic void enumerate_cells(input element_t e);
    longint     ax, ay, bx, by, ex, ey, fx, fy;
    longint     lo_x, lo_y, hi_x, hi_y, d;
    longint     cx0, cy0, cx1, cy1, nx, ny, i, j, key;
    logic [ID_W-1:0] id;
    logic       clip;
    cell_word_t w;
    ax = e.pa_x;
    ay = e.pa_y;
    bx = e.pb_x;
    by = e.pb_y;
    ex = ax + longint'(e.da_x);
    ey = ay + longint'(e.da_y);
    fx = bx + longint'(e.db_x);
    fy = by + longint'(e.db_y);
    lo_x = lesser(ax, ex);
    hi_x = greater(ax, ex);
    lo_y = lesser(ay, ey);
    hi_y = greater(ay, ey);
    if (e.kind == KIND_EDGE) begin
      lo_x = lesser(lo_x, lesser(bx, fx));
      hi_x = greater(hi_x, greater(bx, fx));
      lo_y = lesser(lo_y, lesser(by, fy));
      hi_y = greater(hi_y, greater(by, fy));
    end
    // a zero cell size divides as one
    d = (cell_size_q == '0) ? 64'sd1 : longint'(cell_size_q);
    cx0 = lo_x / d;
    cy0 = lo_y / d;
    cx1 = ceil_div(hi_x, d);
    cy1 = ceil_div(hi_y, d);
    clip = 1'b0;
    nx = span_cells(cx0, cx1, clip);
    ny = span_cells(cy0, cy1, clip);
    id = ID_W'(e.index) + 1'b1;
    if (e.kind == KIND_VERTEX) id = '0 - id;
    for (i = 0; i < nx; i++) begin
      for (j = 0; j < ny; j++) begin
        key = (cy0 + j) * longint'(grid_width_q) + (cx0 + i);
        w.key = key[KEY_W-1:0];
        w.id = id;
        w.last = (i == nx - 1) && (j == ny - 1);
        w.clipped = clip;
        cells_due.insert(cells_due.size(), w);
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic element_t make_element(
    input elem_kind_e kind,
    input logic signed [COORD_W-1:0] pax, pay, pbx, pby,
    input logic signed [COORD_W-1:0] dax, day, dbx, dby,
    input logic [IDX_W-1:0] index
  );
    element_t e;
    e.kind = kind;
    e.pa_x = pax;
    e.pa_y = pay;
    e.pb_x = pbx;
    e.pb_y = pby;
    e.da_x = dax;
    e.da_y = day;
    e.db_x = dbx;
    e.db_y = dby;
    e.index = index;
    return e;
  endfunction

  // element position: anywhere, or within 20 cells of the origin
  function automatic longint rand_anchor(input longint scale);
    if ($urandom_range(0, 2) == 0) return longint'($signed($urandom));
    return (longint'($urandom_range(0, 40)) - 20) * scale;
  endfunction

  // a point from one cell below the anchor to just under two cells above it
  function automatic longint rand_offset(input longint scale);
    return longint'($urandom_range(0, 2)) * scale
         + longint'($urandom_range(0, 32'(scale - 1))) - scale;
  endfunction

  // displacement: mostly a few cells, sometimes anything
  function automatic logic signed [COORD_W-1:0] rand_move(input longint scale);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'((longint'($urandom_range(0, 6)) - 3) * scale
               + longint'($urandom_range(0, 32'(scale - 1))));
  endfunction

  function automatic element_t random_element();
    element_t e;
    longint   scale, ax, ay;
    scale = (cell_size_q == '0) ? 64'sd1 : longint'(cell_size_q);
    ax = rand_anchor(scale);
    ay = rand_anchor(scale);
    e.kind = elem_kind_e'($urandom_range(0, 1));
    e.pa_x = 32'(ax + rand_offset(scale));
    e.pa_y = 32'(ay + rand_offset(scale));
    e.pb_x = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(ax + rand_offset(scale));
    e.pb_y = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(ay + rand_offset(scale));
    e.da_x = rand_move(scale);
    e.da_y = rand_move(scale);
    e.db_x = rand_move(scale);
    e.db_y = rand_move(scale);
    e.index = ($urandom_range(0, 15) == 0) ? IDX_TOP : IDX_W'($urandom);
    return e;
  endfunction

  // one element on the slave stream; expectations queued at the accept edge
  task automatic send_element(input element_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({e.index, e.db_y, e.db_x, e.da_y, e.da_x,
                                 e.pb_y, e.pb_x, e.pa_y, e.pa_x});
    s_axis_tuser  <= e.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    enumerate_cells(e);
  endtask

  task automatic run_random_items(input int count);
    repeat (count) send_element(random_element());
  endtask

  // wait until every predicted cell is out and the block has settled
  task automatic drain_cells();
    s_axis_tvalid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_CELL_SIZE) cell_size_q = value[CS_W-1:0];
    else grid_width_q = value[GW_W-1:0];
  endtask

  task automatic set_grid(input logic [CS_W-1:0] cs, input logic [GW_W-1:0] gw);
    write_register(REG_CELL_SIZE, cs);
    write_register(REG_GRID_WIDTH, CFG_DATA_W'(gw));
  endtask

  // ---------------------------------------------------------------- checking

  initial begin : cell_sink
    int         stall;
    cell_word_t want;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      words_seen++;
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        want = cells_due.pop_front();
        if (m_axis_tdata[KEY_W-1:0] !== want.key)
          report_mismatch($sformatf("word %0d cell_key %h, want %h", words_seen,
                                    m_axis_tdata[KEY_W-1:0], want.key));
        if (m_axis_tdata[KEY_W +: ID_W] !== want.id)
          report_mismatch($sformatf("word %0d element_id %h, want %h", words_seen,
                                    m_axis_tdata[KEY_W +: ID_W], want.id));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("word %0d last %b, want %b", words_seen,
                                    m_axis_tlast, want.last));
        if (m_axis_tuser !== want.clipped)
          report_mismatch($sformatf("word %0d clipped %b, want %b", words_seen,
                                    m_axis_tuser, want.clipped));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset grid: single cells, boundaries, extremes, span limit, id wrap
  task automatic test_reset_defaults();
    send_element(make_element(KIND_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    send_element(make_element(KIND_EDGE, Q_ONE / 2, Q_ONE / 2, Q_ONE + Q_ONE / 2,
                              2 * Q_ONE, 0, 0, 0, 0, IDX_TOP));
    send_element(make_element(KIND_VERTEX, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, IDX_TOP));
    send_element(make_element(KIND_VERTEX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                              Q_MAX, Q_MAX, Q_MAX, Q_MAX, IDX_TOP));
    send_element(make_element(KIND_VERTEX, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0));
    send_element(make_element(KIND_EDGE, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
                              0, 0, 0, 0, 20'h5A5A5));
    // tiny negative start truncates to zero
    send_element(make_element(KIND_VERTEX, -1, -1, 0, 0, 2, 2, 0, 0, 20'd7));
    send_element(make_element(KIND_VERTEX, 3 * Q_ONE, -3 * Q_ONE, 0, 0,
                              Q_ONE, Q_ONE, 0, 0, 20'd8));
    // eight cells per axis fit, nine get clipped
    send_element(make_element(KIND_VERTEX, 0, 0, 0, 0, 7 * Q_ONE, 7 * Q_ONE,
                              0, 0, 20'd9));
    send_element(make_element(KIND_VERTEX, 0, 0, 0, 0, 8 * Q_ONE, 0, 0, 0, 20'd10));
    // second point fields do not matter for a vertex
    send_element(make_element(KIND_VERTEX, Q_ONE, Q_ONE, -1, -1,
                              0, 0, Q_MAX, Q_MIN, 20'hAAAAA));
    // each end point moves by its own displacement
    send_element(make_element(KIND_EDGE, 0, 0, 0, 0, 0, 0, 3 * Q_ONE, 2 * Q_ONE,
                              20'h55555));
    send_element(make_element(KIND_VERTEX, 2 * Q_ONE, 2 * Q_ONE, 0, 0,
                              -5 * Q_ONE, -Q_ONE / 3, 0, 0, 20'd11));
    drain_cells();
  endtask

  // unit cells and widest rows: keys wrap, the edge span clips
  task automatic test_fine_grid();
    set_grid(31'd1, 16'hFFFF);
    send_element(make_element(KIND_VERTEX, Q_MAX, Q_MAX, 0, 0, 0, 0, 0, 0, 20'd1));
    send_element(make_element(KIND_VERTEX, Q_MIN, Q_MIN, 0, 0, 0, 0, 0, 0, 20'd2));
    send_element(make_element(KIND_EDGE, -5, -5, 3, 3, 0, 0, 0, 0, 20'd3));
    drain_cells();
  endtask

  // largest cells with a row width of one
  task automatic test_coarse_grid();
    set_grid(31'h7FFF_FFFF, 16'd1);
    send_element(make_element(KIND_VERTEX, Q_MAX, Q_MAX, 0, 0,
                              Q_MAX, Q_MAX, 0, 0, 20'd4));
    send_element(make_element(KIND_VERTEX, Q_MIN, Q_MIN, 0, 0,
                              Q_MIN, Q_MIN, 0, 0, 20'd5));
    send_element(make_element(KIND_EDGE, Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                              Q_MAX, Q_MIN, Q_MIN, Q_MAX, IDX_TOP));
    drain_cells();
  endtask

  // a cell size of zero divides as one
  task automatic test_zero_cell_size();
    set_grid('0, 16'd10);
    send_element(make_element(KIND_VERTEX, 5, -7, 0, 0, 2, 3, 0, 0, 20'd6));
    send_element(make_element(KIND_EDGE, -2, 1, 1, -1, 1, 1, -2, 0, 20'd12));
    drain_cells();
  endtask

  task automatic test_random_mixed();
    set_grid(CS_W'($urandom_range(1, 32'h0010_0000)), GW_W'($urandom_range(1, 65535)));
    run_random_items(34);
    drain_cells();
  endtask

  // no gaps on either side
  task automatic test_random_back_to_back();
    set_grid(CS_W'(Q_ONE * $urandom_range(1, 4)), GRID_WIDTH_RST);
    no_idle = 1'b1;
    run_random_items(34);
    drain_cells();
    no_idle = 1'b0;
  endtask

  task automatic test_random_wide_cells();
    set_grid(CS_W'($urandom_range(1, 32'h7FFF_FFFF)), GW_W'($urandom_range(1, 65535)));
    run_random_items(34);
    drain_cells();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_fine_grid();
    test_coarse_grid();
    test_zero_cell_size();
    test_random_mixed();
    test_random_back_to_back();
    test_random_wide_cells();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0 && cells_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
